// ===== rtl/sspo_pkg.sv =====
// Shared types, constants and the control store for the suffix-prefix overlap block.
`default_nettype none
package sspo_pkg;

    localparam int MAX_LEN_DEF = 64;
    localparam int CH_W        = 8;
    localparam int OVL_W       = 6;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_TESTK,
        S_READ,
        S_CMP,
        S_CHKJ,
        S_DECK,
        S_DONE
    } step_t;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_FIN,
        C_KZERO,
        C_MISMATCH,
        C_JEQK,
        C_OUTFREE
    } cond_t;

    typedef enum logic [1:0] {
        K_HOLD,
        K_LOAD,
        K_DEC
    } k_op_t;

    typedef enum logic [1:0] {
        J_HOLD,
        J_CLR,
        J_INC
    } j_op_t;

    // One control word: jt is taken when the condition holds, jf otherwise.
    // fin only acts on the cycle its condition holds.
    typedef struct packed {
        logic  rdy;
        cond_t cond;
        step_t jt;
        step_t jf;
        k_op_t k_op;
        j_op_t j_op;
        logic  fin;
    } ctrl_t;

    function automatic ctrl_t sspo_rom(input step_t step);
        ctrl_t w;
        w = '{rdy: 1'b0, cond: C_ALWAYS, jt: S_IDLE, jf: S_IDLE,
              k_op: K_HOLD, j_op: J_HOLD, fin: 1'b0};
        unique case (step)
            S_IDLE:  w = '{1'b1, C_FIN,      S_INIT,  S_IDLE, K_HOLD, J_HOLD, 1'b0};
            S_INIT:  w = '{1'b0, C_ALWAYS,   S_TESTK, S_TESTK, K_LOAD, J_HOLD, 1'b0};
            S_TESTK: w = '{1'b0, C_KZERO,    S_DONE,  S_READ, K_HOLD, J_CLR,  1'b0};
            S_READ:  w = '{1'b0, C_ALWAYS,   S_CMP,   S_CMP,  K_HOLD, J_HOLD, 1'b0};
            S_CMP:   w = '{1'b0, C_MISMATCH, S_DECK,  S_CHKJ, K_HOLD, J_INC,  1'b0};
            S_CHKJ:  w = '{1'b0, C_JEQK,     S_DONE,  S_READ, K_HOLD, J_HOLD, 1'b0};
            S_DECK:  w = '{1'b0, C_ALWAYS,   S_TESTK, S_TESTK, K_DEC, J_HOLD, 1'b0};
            S_DONE:  w = '{1'b0, C_OUTFREE,  S_IDLE,  S_DONE, K_HOLD, J_HOLD, 1'b1};
            default: w = '{1'b0, C_ALWAYS,   S_IDLE,  S_IDLE, K_HOLD, J_HOLD, 1'b0};
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/sspo_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sspo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/string_suffix_prefix_overlap.sv =====
// The result is offered after the states S_INIT, S_TESTK and S_DONE when no overlap test
// is needed, and otherwise once the search ends; a sequencer tests each byte pair in the
// states S_READ, S_CMP and S_CHKJ, and moves to the next candidate through S_DECK.
// Throughput: one input byte per cycle while a pair is loading; no bytes are taken
// during the search. A finished result waits in an output register while loading resumes.
// Reset: asynchronous, active low; clears lengths, overflow flag, step counter, output valid.
`default_nettype none
module string_suffix_prefix_overlap
    import sspo_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire logic [CH_W-1:0] s_tdata,   // [7:0] ch
    input  wire logic            s_tuser,   // [0] command: 0 first string, 1 second string
    input  wire logic            s_tlast,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output logic [7:0]           m_tdata    // [5:0] overlap, [6] truncated, [7] zero
);

    localparam int LEN_W = $clog2(MAX_LEN + 1);
    localparam int AW    = $clog2(MAX_LEN);

    step_t             upc_reg, upc_next;
    ctrl_t             ctrl;
    logic              take;
    logic              s_acc;
    logic              done_fire;

    logic [LEN_W-1:0]  first_len_reg, first_len_next;
    logic [LEN_W-1:0]  second_len_reg, second_len_next;
    logic              ovf_reg, ovf_next;
    logic [LEN_W-1:0]  k_reg, k_next;
    logic [LEN_W-1:0]  j_reg, j_next;
    logic [LEN_W-1:0]  shorter;

    logic              m_valid_reg, m_valid_next;
    logic [OVL_W-1:0]  ovl_reg;
    logic              trunc_reg;

    logic              first_we, second_we;
    logic              first_full, second_full;
    logic [AW-1:0]     first_raddr, second_raddr;
    logic [CH_W-1:0]   first_rdata, second_rdata;

    assign ctrl  = sspo_rom(upc_reg);
    assign s_acc = s_tvalid && ctrl.rdy;

    // Condition select and next step.
    always_comb
    begin
        unique case (ctrl.cond)
            C_ALWAYS:   take = 1'b1;
            C_FIN:      take = s_acc && s_tuser && s_tlast;
            C_KZERO:    take = (k_reg == '0);
            C_MISMATCH: take = (first_rdata != second_rdata);
            C_JEQK:     take = (j_reg == k_reg);
            C_OUTFREE:  take = !m_valid_reg || m_tready;
            default:    take = 1'b0;
        endcase
        upc_next = take ? ctrl.jt : ctrl.jf;
    end

    assign done_fire = ctrl.fin && take;

    // Buffer loading.
    assign first_full  = (first_len_reg >= LEN_W'(MAX_LEN));
    assign second_full = (second_len_reg >= LEN_W'(MAX_LEN));
    assign first_we    = s_acc && !s_tuser && !first_full;
    assign second_we   = s_acc && s_tuser && !second_full;

    always_comb
    begin
        first_len_next  = first_len_reg;
        second_len_next = second_len_reg;
        ovf_next        = ovf_reg;
        if (done_fire)
        begin
            first_len_next  = '0;
            second_len_next = '0;
            ovf_next        = 1'b0;
        end
        else if (s_acc)
        begin
            if (first_we)
            begin
                first_len_next = first_len_reg + 1'b1;
            end
            if (second_we)
            begin
                second_len_next = second_len_reg + 1'b1;
            end
            if ((!s_tuser && first_full) || (s_tuser && second_full))
            begin
                ovf_next = 1'b1;
            end
        end
    end

    // Overlap search datapath.
    assign shorter = (first_len_reg < second_len_reg) ? first_len_reg : second_len_reg;

    always_comb
    begin
        case (ctrl.k_op)
            K_LOAD:  k_next = (shorter == '0) ? '0 : shorter - 1'b1;
            K_DEC:   k_next = k_reg - 1'b1;
            default: k_next = k_reg;
        endcase
        case (ctrl.j_op)
            J_CLR:   j_next = '0;
            J_INC:   j_next = j_reg + 1'b1;
            default: j_next = j_reg;
        endcase
    end

    // Candidate k aligns the first string's tail at first_len - k with the second's head.
    assign first_raddr  = AW'(first_len_reg - k_reg + j_reg);
    assign second_raddr = AW'(j_reg);

    assign m_valid_next = done_fire ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg        <= S_IDLE;
            first_len_reg  <= '0;
            second_len_reg <= '0;
            ovf_reg        <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            upc_reg        <= upc_next;
            first_len_reg  <= first_len_next;
            second_len_reg <= second_len_next;
            ovf_reg        <= ovf_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg <= k_next;
        j_reg <= j_next;
        if (done_fire)
        begin
            ovl_reg   <= OVL_W'(k_reg);
            trunc_reg <= ovf_reg;
        end
    end

    sspo_ram #(
        .WIDTH (CH_W),
        .DEPTH (MAX_LEN)
    ) u_first_ram (
        .clk   (clk),
        .we    (first_we),
        .waddr (AW'(first_len_reg)),
        .wdata (s_tdata),
        .raddr (first_raddr),
        .rdata (first_rdata)
    );

    sspo_ram #(
        .WIDTH (CH_W),
        .DEPTH (MAX_LEN)
    ) u_second_ram (
        .clk   (clk),
        .we    (second_we),
        .waddr (AW'(second_len_reg)),
        .wdata (s_tdata),
        .raddr (second_raddr),
        .rdata (second_rdata)
    );

    assign s_tready = ctrl.rdy;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, trunc_reg, ovl_reg};

endmodule
`default_nettype wire

// ===== rtl/sspo_checker.sv =====
// Port-level checks for the suffix-prefix overlap block and the bind that attaches them.
`default_nettype none
module sspo_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic       s_tuser,
    input wire logic       s_tlast,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata
);

    // A result waiting for the sink keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // The end of the second string starts the search, so loading stops.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser && s_tlast |=> !s_tready)
        else $error("input still ready after the end of a pair");

    // A new result only appears out of the search, never during loading.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared while loading");

    // The padding bit of the result is always zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !m_tdata[7])
        else $error("result padding bit set");

endmodule

bind string_suffix_prefix_overlap sspo_checker u_sspo_checker (.*);
`default_nettype wire
